>>> sv/cfa_pkg.sv
// Package for the contiguous fit allocator: constants, policy codes, FSM states and
// the command/status structs between controller and datapath. No dependencies.
`default_nettype none
package cfa_pkg;
    localparam int MEM_WORDS_DEF = 1024;
    localparam int SIZE_W = 11;
    localparam int BASE_W = 10;

    typedef enum logic [1:0] {
        POL_FIRST = 2'd0,
        POL_NEXT  = 2'd1,
        POL_BEST  = 2'd2,
        POL_WORST = 2'd3
    } policy_t;

    typedef enum logic [0:0] {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_MARK,
        ST_FREE_RD,
        ST_FREE_WAIT,
        ST_FREE_CHK,
        ST_UNMARK,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;        // capture the request
        logic clr_step;    // clear pass: write zero at pointer, advance
        logic scan_start;  // begin search
        logic scan_step;   // examine one word
        logic mark_step;   // write one word of the chosen block
        logic lut_read;    // read the length table at the free base
        logic unmark_step; // clear one word of the freed block
        logic finish_ok;   // build a granted result
        logic finish_bad;  // build a denied result
        logic out_load;    // load output register
    } cmd_t;

    typedef struct packed {
        logic clr_done;
        logic is_free;
        logic size_ok;
        logic scan_done;
        logic found;
        logic mark_done;
        logic len_ok;
        logic unmark_done;
        logic out_busy;
    } sts_t;
endpackage
`default_nettype wire

>>> sv/cfa_if.sv
// Valid/ready channel interfaces for request and result items.
// Depends on cfa_pkg for field widths.
`default_nettype none
interface cfa_req_if;
    logic valid;
    logic ready;
    logic operation;
    logic [cfa_pkg::SIZE_W-1:0] alloc_size;
    logic [cfa_pkg::BASE_W-1:0] block_base;
    modport source (output valid, operation, alloc_size, block_base, input ready);
    modport sink   (input valid, operation, alloc_size, block_base, output ready);
endinterface

interface cfa_rsp_if;
    logic valid;
    logic ready;
    logic granted;
    logic [cfa_pkg::BASE_W-1:0] result_base;
    logic [cfa_pkg::SIZE_W-1:0] freed_length;
    modport source (output valid, granted, result_base, freed_length, input ready);
    modport sink   (input valid, granted, result_base, freed_length, output ready);
endinterface
`default_nettype wire

>>> sv/contiguous_fit_allocator_top.sv
// Contiguous fit allocator over an occupancy bitmap of MEM_WORDS words. After reset
// a clearing pass over every word runs before the first item is taken. An allocate
// scans the bitmap, reading each registered bitmap word and then testing it (a next
// fit that finds nothing from a nonzero rover wraps for a second pass from word zero),
// and marks its block one word per cycle; a free reads and checks the length table,
// then unmarks one word per cycle. One item is handled at a time; the result waits in
// its own output register, so the next item can be taken while it is held.
// Depends on cfa_pkg, cfa_if, cfa_ctrl and cfa_dp.
`default_nettype none
module contiguous_fit_allocator_top #(
    parameter int MEM_WORDS = cfa_pkg::MEM_WORDS_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [1:0] cfg_wdata,
    cfa_req_if.sink         req,
    cfa_rsp_if.source       rsp
);
    import cfa_pkg::*;

    logic [1:0] policy_reg;
    cmd_t cmd;
    sts_t sts;

    // Policy register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            policy_reg <= POL_FIRST;
        else if (cfg_we)
            policy_reg <= cfg_wdata;
    end

    cfa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    cfa_dp #(.MEM_WORDS(MEM_WORDS)) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .fit_policy       (policy_reg),
        .in_operation     (req.operation),
        .in_alloc_size    (req.alloc_size),
        .in_block_base    (req.block_base),
        .cmd              (cmd),
        .sts              (sts),
        .out_valid        (rsp.valid),
        .out_ready        (rsp.ready),
        .out_granted      (rsp.granted),
        .out_result_base  (rsp.result_base),
        .out_freed_length (rsp.freed_length)
    );
endmodule
`default_nettype wire

>>> sv/cfa_ctrl.sv
// Controller state machine for the allocator.
// Depends on cfa_pkg for states, command and status structs.
`default_nettype none
module cfa_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  cfa_pkg::sts_t      sts,
    output cfa_pkg::cmd_t      cmd
);
    import cfa_pkg::*;

    state_t state_reg, state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CLEAR;
        else
            state_reg <= state_next;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:     if (sts.clr_done) state_next = ST_IDLE;
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_FREE_RD;
            end
            ST_FREE_RD:
            begin
                if (sts.is_free)
                    state_next = ST_FREE_WAIT;
                else if (sts.size_ok)
                    state_next = ST_SCAN;
                else
                    state_next = ST_DONE;
            end
            ST_FREE_WAIT: state_next = ST_FREE_CHK;
            ST_FREE_CHK:  state_next = sts.len_ok ? ST_UNMARK : ST_DONE;
            ST_UNMARK:    if (sts.unmark_done) state_next = ST_DONE;
            ST_SCAN:
            begin
                if (sts.scan_done)
                    state_next = sts.found ? ST_MARK : ST_DONE;
            end
            ST_MARK:      if (sts.mark_done) state_next = ST_DONE;
            ST_DONE:      if (!sts.out_busy) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // Outputs.
    always_comb
    begin
        cmd = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_CLEAR: cmd.clr_step = 1'b1;
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_FREE_RD:
            begin
                cmd.lut_read = sts.is_free;
                cmd.scan_start = !sts.is_free && sts.size_ok;
                cmd.finish_bad = !sts.is_free && !sts.size_ok;
            end
            ST_FREE_WAIT: ;
            ST_FREE_CHK:  cmd.finish_bad = !sts.len_ok;
            ST_UNMARK:
            begin
                cmd.unmark_step = 1'b1;
                cmd.finish_ok = sts.unmark_done;
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                cmd.finish_bad = sts.scan_done && !sts.found;
            end
            ST_MARK:
            begin
                cmd.mark_step = 1'b1;
                cmd.finish_ok = sts.mark_done;
            end
            ST_DONE:      cmd.out_load = !sts.out_busy;
            default: ;
        endcase
    end
endmodule
`default_nettype wire

>>> sv/cfa_dp.sv
// Datapath: occupancy bitmap and length table memories, the run scanner,
// mark/unmark sequencer and result register. Depends on cfa_pkg.
`default_nettype none
module cfa_dp #(
    parameter int MEM_WORDS = cfa_pkg::MEM_WORDS_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic [1:0]                 fit_policy,
    input  wire logic                       in_operation,
    input  wire logic [cfa_pkg::SIZE_W-1:0] in_alloc_size,
    input  wire logic [cfa_pkg::BASE_W-1:0] in_block_base,
    input  cfa_pkg::cmd_t                   cmd,
    output cfa_pkg::sts_t                   sts,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic                            out_granted,
    output logic [cfa_pkg::BASE_W-1:0]      out_result_base,
    output logic [cfa_pkg::SIZE_W-1:0]      out_freed_length
);
    import cfa_pkg::*;

    localparam int AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
    localparam int CW = $clog2(MEM_WORDS + 1);
    localparam logic [CW-1:0] TOP = CW'(MEM_WORDS);

    // Memories.
    logic              occ_mem [MEM_WORDS];
    logic [SIZE_W-1:0] len_mem [MEM_WORDS];

    // Request and search registers.
    logic              op_reg;
    logic [SIZE_W-1:0] size_reg;
    logic [BASE_W-1:0] fbase_reg;
    logic [CW-1:0]     ptr_reg;      // clear pointer, scan pointer, mark and unmark pointer
    logic [CW-1:0]     cnt_reg;      // current free run length
    logic [CW-1:0]     start_reg;    // current run start
    logic [CW-1:0]     pick_reg;
    logic [CW-1:0]     pick_len_reg;
    logic              found_reg;
    logic              pass2_reg;    // next fit wrap pass
    logic              phase_reg;    // scan: 0 reads a word, 1 tests it
    logic [CW-1:0]     rover_reg;
    logic [CW-1:0]     lim_reg;      // runs may start only below this
    logic [CW-1:0]     end_reg;      // mark/unmark end
    logic              occ_q;
    logic [SIZE_W-1:0] len_q;
    logic              out_valid_reg;
    logic              g_reg;
    logic [BASE_W-1:0] rb_reg;
    logic [SIZE_W-1:0] fl_reg;
    logic              out_g_reg;
    logic [BASE_W-1:0] out_rb_reg;
    logic [SIZE_W-1:0] out_fl_reg;
    logic              flen_chk;
    logic              chk_phase_reg;
    logic              chk2_reg;

    logic [AW-1:0] waddr;
    logic          linear;
    logic [CW-1:0] size_c;
    logic          occ_rd;
    logic          free_w;
    logic [CW-1:0] cnt_inc;
    logic          run_close;
    logic          better;
    logic          hit_lin;
    logic          at_top;
    logic [CW-1:0] sz_wide;

    assign waddr   = ptr_reg[AW-1:0];
    assign linear  = (fit_policy == POL_FIRST) || (fit_policy == POL_NEXT);
    assign sz_wide = (SIZE_W >= CW) ? CW'(size_reg) : CW'(size_reg);
    assign size_c  = sz_wide;
    assign at_top  = (ptr_reg == TOP);
    assign occ_rd  = at_top ? 1'b1 : occ_q;
    assign free_w  = !occ_rd;
    assign cnt_inc = cnt_reg + CW'(1);
    assign run_close = !free_w && (cnt_reg != '0) && (cnt_reg >= size_c);
    assign better  = !found_reg ||
                     ((fit_policy == POL_WORST) ? (cnt_reg > pick_len_reg)
                                                : (cnt_reg < pick_len_reg));
    assign hit_lin = free_w && (cnt_reg != '0 || ptr_reg < lim_reg) && (cnt_inc == size_c);

    // Memory writes and registered reads.
    always_ff @(posedge clk)
    begin
        if (cmd.clr_step)
        begin
            occ_mem[waddr] <= 1'b0;
            len_mem[waddr] <= '0;
        end
        else if (cmd.mark_step)
        begin
            occ_mem[waddr] <= 1'b1;
            if (ptr_reg == pick_reg)
                len_mem[waddr] <= size_reg;
        end
        else if (cmd.unmark_step)
        begin
            occ_mem[waddr] <= 1'b0;
            if (ptr_reg == CW'(fbase_reg))
                len_mem[waddr] <= '0;
        end
        if (cmd.lut_read)
            len_q <= len_mem[fbase_reg[AW-1:0]];
        occ_q <= occ_mem[waddr];
    end

    // Control registers of the datapath.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg <= '0;
            rover_reg <= '0;
            out_valid_reg <= 1'b0;
            found_reg <= 1'b0;
            pass2_reg <= 1'b0;
            phase_reg <= 1'b0;
            cnt_reg <= '0;
            start_reg <= '0;
            pick_reg <= '0;
            pick_len_reg <= '0;
            lim_reg <= '0;
            end_reg <= '0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            if (cmd.out_load)
                out_valid_reg <= 1'b1;

            if (cmd.clr_step)
                ptr_reg <= ptr_reg + CW'(1);
            else if (cmd.load)
                ptr_reg <= '0;
            else if (cmd.scan_start)
            begin
                ptr_reg <= (fit_policy == POL_NEXT) ? rover_reg : '0;
                lim_reg <= TOP;
                cnt_reg <= '0;
                found_reg <= 1'b0;
                pass2_reg <= 1'b0;
                phase_reg <= 1'b0;
            end
            else if (cmd.scan_step)
            begin
                // A scan step alternates between reading one bitmap word and testing it.
                if (!phase_reg)
                    phase_reg <= 1'b1;
                else
                begin
                    phase_reg <= 1'b0;
                    if (linear)
                    begin
                        if (hit_lin)
                        begin
                            found_reg <= 1'b1;
                            pick_reg <= (cnt_reg == '0) ? ptr_reg : start_reg;
                            ptr_reg <= (cnt_reg == '0) ? ptr_reg : start_reg;
                            end_reg <= ((cnt_reg == '0) ? ptr_reg : start_reg) + size_c;
                        end
                        else if (at_top || (free_w && cnt_reg == '0 && ptr_reg >= lim_reg))
                        begin
                            if (fit_policy == POL_NEXT && !pass2_reg && rover_reg != '0)
                            begin
                                pass2_reg <= 1'b1;
                                lim_reg <= rover_reg;
                                ptr_reg <= '0;
                                cnt_reg <= '0;
                            end
                            else
                                pass2_reg <= 1'b1;
                        end
                        else
                        begin
                            if (free_w)
                            begin
                                if (cnt_reg == '0)
                                    start_reg <= ptr_reg;
                                cnt_reg <= cnt_inc;
                            end
                            else
                                cnt_reg <= '0;
                            ptr_reg <= ptr_reg + CW'(1);
                        end
                    end
                    else
                    begin
                        if (free_w)
                        begin
                            if (cnt_reg == '0)
                                start_reg <= ptr_reg;
                            cnt_reg <= cnt_inc;
                        end
                        else
                        begin
                            if (run_close && better)
                            begin
                                found_reg <= 1'b1;
                                pick_reg <= start_reg;
                                pick_len_reg <= cnt_reg;
                            end
                            cnt_reg <= '0;
                        end
                        if (at_top)
                            pass2_reg <= 1'b1;
                        else
                            ptr_reg <= ptr_reg + CW'(1);
                    end
                end
            end
            else if (cmd.mark_step)
                ptr_reg <= ptr_reg + CW'(1);
            else if (cmd.unmark_step)
                ptr_reg <= ptr_reg + CW'(1);

            // Extreme fit: set up the mark range once the scan ends.
            if (cmd.scan_step && phase_reg && !linear && at_top)
            begin
                ptr_reg <= (run_close && better) ? start_reg : pick_reg;
                end_reg <= ((run_close && better) ? start_reg : pick_reg) + size_c;
            end
            // Free: start unmark range from the recorded length.
            if (sts.len_ok && !cmd.finish_bad && flen_chk)
            begin
                ptr_reg <= CW'(fbase_reg);
                end_reg <= CW'(fbase_reg) + CW'(len_q);
            end
            if (cmd.mark_step && sts.mark_done && fit_policy == POL_NEXT)
                rover_reg <= end_reg;
        end
    end

    // Track the length table read so the unmark range is set in the check cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            chk_phase_reg <= 1'b0;
        else
            chk_phase_reg <= cmd.lut_read;
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            chk2_reg <= 1'b0;
        else
            chk2_reg <= chk_phase_reg;
    end
    assign flen_chk = chk2_reg;

    // Request capture, result build and output register.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg <= in_operation;
            size_reg <= in_alloc_size;
            fbase_reg <= in_block_base;
        end
        if (cmd.finish_ok)
        begin
            g_reg <= 1'b1;
            rb_reg <= (op_reg == OP_FREE) ? '0 : BASE_W'(pick_reg);
            fl_reg <= (op_reg == OP_FREE) ? len_q : '0;
        end
        else if (cmd.finish_bad)
        begin
            g_reg <= 1'b0;
            rb_reg <= '0;
            fl_reg <= '0;
        end
        // The output item stays fixed while it waits for the sink.
        if (cmd.out_load)
        begin
            out_g_reg <= g_reg;
            out_rb_reg <= rb_reg;
            out_fl_reg <= fl_reg;
        end
    end

    // Status to the controller.
    always_comb
    begin
        sts = '0;
        sts.clr_done    = (ptr_reg == TOP - CW'(1));
        sts.is_free     = (op_reg == OP_FREE);
        sts.size_ok     = (size_reg != '0) && ({1'b0, size_reg} <= (SIZE_W+1)'(MEM_WORDS));
        sts.scan_done   = phase_reg &&
                          (linear ? (hit_lin || ((at_top ||
                              (free_w && cnt_reg == '0 && ptr_reg >= lim_reg)) &&
                              !(fit_policy == POL_NEXT && !pass2_reg && rover_reg != '0)))
                                  : at_top);
        sts.found       = linear ? hit_lin : (found_reg || (run_close && better));
        sts.mark_done   = (ptr_reg + CW'(1) == end_reg);
        sts.len_ok      = ((SIZE_W+1)'(fbase_reg) < (SIZE_W+1)'(MEM_WORDS)) && (len_q != '0);
        sts.unmark_done = (ptr_reg + CW'(1) >= end_reg) || (ptr_reg + CW'(1) == TOP);
        sts.out_busy    = out_valid_reg && !out_ready;
    end

    assign out_valid        = out_valid_reg;
    assign out_granted      = out_g_reg;
    assign out_result_base  = out_rb_reg;
    assign out_freed_length = out_fl_reg;
endmodule
`default_nettype wire

>>> bench/tb_contiguous_fit_allocator_top.sv
// Self-checking bench for the contiguous fit allocator: drives request items, predicts
// grants, bases and freed lengths, and checks every result item in order.
// Depends on cfa_pkg, cfa_if and contiguous_fit_allocator_top.
`timescale 1ns / 100ps
module tb_contiguous_fit_allocator_top;
    import cfa_pkg::*;

    localparam int WORDS = MEM_WORDS_DEF;
    localparam int NONE  = -1;

    // One expected result item.
    typedef struct packed {
        logic             granted;
        logic [BASE_W-1:0] result_base;
        logic [SIZE_W-1:0] freed_length;
    } outcome_t;

    // Scoreboard: allocator state copy plus a queue of pending outcomes.
    class alloc_scoreboard;
        bit        used_map [WORDS];
        int        len_tab  [WORDS];
        int        rover;
        policy_t   policy;
        outcome_t  pending [$];
        int        errors;
        int        checked;

        function void clear();
            foreach (used_map[i])
            begin
                used_map[i] = 0;
                len_tab[i]  = 0;
            end
            rover  = 0;
            policy = POL_FIRST;
        endfunction

        // Print one mismatch line and count it.
        task report_mismatch(string what, int got, int want);
            errors++;
            $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        endtask

        // Lowest run start at or after lo that holds n words; starts below hi only.
        function int linear_fit(int lo, int hi, int n);
            int start;
            int cnt;
            start = 0;
            cnt = 0;
            for (int p = lo; p < WORDS; p++)
            begin
                if (used_map[p])
                begin
                    cnt = 0;
                end
                else
                begin
                    if (cnt == 0)
                    begin
                        if (p >= hi) return NONE;
                        start = p;
                    end
                    cnt++;
                    if (cnt == n) return start;
                end
            end
            return NONE;
        endfunction

        // Smallest or largest maximal free run of at least n words.
        function int extreme_fit(int n, bit largest);
            int pick;
            int pick_len;
            int start;
            int cnt;
            pick = NONE;
            pick_len = 0;
            start = 0;
            cnt = 0;
            for (int p = 0; p <= WORDS; p++)
            begin
                if (p < WORDS && !used_map[p])
                begin
                    if (cnt == 0) start = p;
                    cnt++;
                end
                else
                begin
                    if (cnt >= n && cnt > 0)
                    begin
                        if (pick == NONE || (largest ? cnt > pick_len : cnt < pick_len))
                        begin
                            pick = start;
                            pick_len = cnt;
                        end
                    end
                    cnt = 0;
                end
            end
            return pick;
        endfunction

        // Note an accepted request item and queue its outcome.
        function void note_request(op_t op, int size, int base_in);
            outcome_t o;
            int b;
            o = '0;
            if (op == OP_ALLOC)
            begin
                b = NONE;
                if (size != 0 && size <= WORDS)
                begin
                    case (policy)
                        POL_FIRST: b = linear_fit(0, WORDS, size);
                        POL_NEXT:
                        begin
                            b = linear_fit(rover, WORDS, size);
                            if (b == NONE) b = linear_fit(0, rover, size);
                            if (b != NONE) rover = b + size;
                        end
                        POL_BEST:  b = extreme_fit(size, 0);
                        default:   b = extreme_fit(size, 1);
                    endcase
                end
                if (b != NONE && b + size <= WORDS)
                begin
                    for (int k = 0; k < size; k++) used_map[b + k] = 1;
                    len_tab[b] = size;
                    o.granted = 1;
                    o.result_base = BASE_W'(b);
                end
            end
            else if (len_tab[base_in] != 0)
            begin
                for (int k = 0; k < len_tab[base_in] && base_in + k < WORDS; k++)
                    used_map[base_in + k] = 0;
                o.granted = 1;
                o.freed_length = SIZE_W'(len_tab[base_in]);
                len_tab[base_in] = 0;
            end
            pending.push_back(o);
        endfunction

        // Compare one result item with the oldest outcome.
        task check_result(outcome_t got);
            outcome_t w;
            checked++;
            if (pending.size() == 0)
            begin
                report_mismatch("result item with nothing pending", 0, 0);
                return;
            end
            w = pending.pop_front();
            if (got.granted !== w.granted)
                report_mismatch("granted", got.granted, w.granted);
            if (got.result_base !== w.result_base)
                report_mismatch("result_base", got.result_base, w.result_base);
            if (got.freed_length !== w.freed_length)
                report_mismatch("freed_length", got.freed_length, w.freed_length);
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [1:0] cfg_wdata;
    cfa_req_if req ();
    cfa_rsp_if rsp ();

    alloc_scoreboard sb;
    int send_idle_pct;
    int recv_idle_pct;
    int live_blocks [$];
    int n_items;

    contiguous_fit_allocator_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req.sink),
        .rsp       (rsp.source)
    );

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    // Generous run limit.
    initial
    begin
        #300ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Result side: random stalls, check at each accepted result item.
    initial
    begin
        rsp.ready = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp.valid && rsp.ready)
                sb.check_result({rsp.granted, rsp.result_base, rsp.freed_length});
            rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Drive one request item and wait until it is accepted. Valid stays high
    // afterwards; the next call or the caller drops it.
    task automatic send_request(op_t op, int size, int base_in);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req.valid <= 0;
            @(posedge clk);
        end
        req.valid <= 1;
        req.operation <= op;
        req.alloc_size <= SIZE_W'(size);
        req.block_base <= BASE_W'(base_in);
        do @(posedge clk); while (!req.ready);
        sb.note_request(op, size, base_in);
        if (op == OP_ALLOC && sb.pending[$].granted)
            live_blocks.push_back(int'(sb.pending[$].result_base));
        n_items++;
    endtask

    // Wait for all results, let the block settle, then change policy.
    task automatic set_policy(policy_t p);
        req.valid <= 0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        cfg_we <= 1;
        cfg_wdata <= p;
        @(posedge clk);
        cfg_we <= 0;
        sb.policy = p;
    endtask

    // Random traffic: mostly sensible sizes and frees of live blocks, some noise.
    task automatic random_phase(int count);
        int r;
        int idx;
        repeat (count)
        begin
            r = $urandom_range(99);
            if (r < 50)
            begin
                send_request(OP_ALLOC, (r < 3) ? $urandom_range(2047) : $urandom_range(1, 96),
                             $urandom_range(1023));
            end
            else if (r < 88 && live_blocks.size() != 0)
            begin
                idx = $urandom_range(live_blocks.size() - 1);
                send_request(OP_FREE, $urandom_range(2047), live_blocks[idx]);
                live_blocks.delete(idx);
            end
            else
            begin
                send_request(OP_FREE, $urandom_range(2047), $urandom_range(1023));
            end
        end
    endtask

    // Main sequence.
    initial
    begin
        sb = new();
        sb.clear();
        rst_n = 0;
        cfg_we = 0;
        cfg_wdata = '0;
        req.valid = 0;
        req.operation = OP_ALLOC;
        req.alloc_size = '0;
        req.block_base = '0;
        send_idle_pct = 10;
        recv_idle_pct = 85;
        n_items = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1;

        // Directed: zero, oversized, full memory, free unknown bases, each policy.
        send_request(OP_ALLOC, 0, 1023);
        send_request(OP_ALLOC, 1025, 0);
        send_request(OP_ALLOC, 2047, 0);
        send_request(OP_ALLOC, 1024, 0);
        send_request(OP_ALLOC, 1, 0);
        send_request(OP_FREE, 0, 0);
        send_request(OP_FREE, 2047, 0);
        send_request(OP_FREE, 0, 1023);
        send_request(OP_ALLOC, 10, 0);
        send_request(OP_ALLOC, 20, 0);
        send_request(OP_ALLOC, 5, 0);
        send_request(OP_FREE, 0, 10);
        set_policy(POL_BEST);
        send_request(OP_ALLOC, 4, 0);
        set_policy(POL_WORST);
        send_request(OP_ALLOC, 3, 0);
        set_policy(POL_NEXT);
        send_request(OP_ALLOC, 8, 0);
        send_request(OP_ALLOC, 1000, 0);
        send_request(OP_ALLOC, 6, 0);
        send_request(OP_ALLOC, 1, 1023);

        // Random phases across all policies and idling profiles.
        random_phase(150);
        set_policy(POL_FIRST);
        send_idle_pct = 85;
        recv_idle_pct = 10;
        random_phase(140);
        set_policy(POL_BEST);
        random_phase(140);
        set_policy(POL_WORST);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(150);

        req.valid <= 0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        $display("covered %0d request items, %0d results, all four fit policies",
                 n_items, sb.checked);
        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

>>> contiguous_fit_allocator_top.f
sv/cfa_pkg.sv
sv/cfa_if.sv
sv/cfa_ctrl.sv
sv/cfa_dp.sv
sv/contiguous_fit_allocator_top.sv
bench/tb_contiguous_fit_allocator_top.sv
